### rtl/crse_pkg.sv
package crse_pkg;

  // request kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam int STATUS_WIDTH = 2;
  localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

  localparam int SEGMENT_WIDTH = 6;

  // coordinate selects
  localparam logic [1:0] COORD_X = 2'd0;
  localparam logic [1:0] COORD_Y = 2'd1;
  localparam logic [1:0] COORD_Z = 2'd2;

  // Horner steps: which coefficient joins the product
  localparam logic [1:0] STEP_A2 = 2'd0;
  localparam logic [1:0] STEP_A1 = 2'd1;
  localparam logic [1:0] STEP_A0 = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       decode;
    logic       scale;
    logic       index;
    logic       rd;
    logic       qpt;
    logic       coef;
    logic       mul;
    logic       add;
    logic       div_load;
    logic       div_step;
    logic       store;
    logic       publish;
    logic [1:0] sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic query_go;
  } dp_stat_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [2:0] rem;
  } div6_t;

  // One radix-16 digit of a division by six; r holds remainder and next digit.
  function automatic div6_t div6_digit(input logic [6:0] r);
    div6_t      d;
    logic [6:0] left;
    d.digit = '0;
    for (int k = 1; k < 16; k++) begin
      if (r >= 7'(6 * k)) d.digit = 4'(k);
    end
    left  = r - {1'b0, d.digit, 2'b00} - {2'b00, d.digit, 1'b0};
    d.rem = left[2:0];
    return d;
  endfunction

endpackage

### rtl/crse_ram.sv
module crse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/crse_ctrl.sv
module crse_ctrl #(
  parameter int DIV_DIGITS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output crse_pkg::ctl_cmd_t  cmd,
  input  crse_pkg::dp_stat_t  stat
);
  import crse_pkg::*;

  localparam int DCW = $clog2(DIV_DIGITS);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_DIGITS - 1);
  localparam logic [1:0]     RD_LAST  = 2'd3;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCALE   = 4'd2;
  localparam logic [3:0] S_INDEX   = 4'd3;
  localparam logic [3:0] S_READ    = 4'd4;
  localparam logic [3:0] S_RDWAIT  = 4'd5;
  localparam logic [3:0] S_QPT     = 4'd6;
  localparam logic [3:0] S_COEF    = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_ADD     = 4'd9;
  localparam logic [3:0] S_DIVL    = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;
  localparam logic [3:0] S_STORE   = 4'd12;
  localparam logic [3:0] S_PUBLISH = 4'd13;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     step_r, step_nxt;
  logic [1:0]     coord_r, coord_nxt;
  logic [DCW-1:0] div_r, div_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    coord_nxt = coord_r;
    div_nxt   = div_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = stat.query_go ? S_SCALE : S_PUBLISH;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_INDEX;
      end
      S_INDEX: begin
        cmd.index = 1'b1;
        step_nxt  = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd   = 1'b1;
        cmd.sel  = step_r;
        step_nxt = step_r + 2'd1;
        if (step_r == RD_LAST) state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        coord_nxt = COORD_X;
        state_nxt = S_QPT;
      end
      S_QPT: begin
        cmd.qpt   = 1'b1;
        cmd.sel   = coord_r;
        state_nxt = S_COEF;
      end
      S_COEF: begin
        cmd.coef  = 1'b1;
        step_nxt  = STEP_A2;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        cmd.sel = step_r;
        if (step_r == STEP_A0) begin
          state_nxt = S_DIVL;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        div_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_r == DIV_LAST) begin
          state_nxt = S_STORE;
        end else begin
          div_nxt = div_r + DCW'(1);
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        cmd.sel   = coord_r;
        if (coord_r == COORD_Z) begin
          state_nxt = S_PUBLISH;
        end else begin
          coord_nxt = coord_r + 2'd1;
          state_nxt = S_QPT;
        end
      end
      S_PUBLISH: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.publish ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      coord_r     <= COORD_X;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      coord_r     <= coord_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && in_valid |=> state_r == S_DECODE)
    else $error("accepted request did not move to decode");

  a_horner_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> step_r == STEP_A2 || step_r == STEP_A1 || step_r == STEP_A0)
    else $error("Horner step counter out of range");

  a_publish_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUBLISH) && !(out_valid_r && out_stall) |=>
      out_valid_r && (state_r == S_IDLE))
    else $error("free output register did not take the result");

endmodule

### rtl/crse_dpath.sv
module crse_dpath #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  crse_pkg::ctl_cmd_t                     cmd,
  output crse_pkg::dp_stat_t                     stat,
  input  logic                                   in_operation,
  input  logic                                   in_first_point,
  input  logic signed [COORD_WIDTH-1:0]          in_x_in,
  input  logic signed [COORD_WIDTH-1:0]          in_y_in,
  input  logic signed [COORD_WIDTH-1:0]          in_z_in,
  input  logic [T_FRAC_BITS:0]                   in_t_in,
  output logic signed [COORD_WIDTH-1:0]          out_x_out,
  output logic signed [COORD_WIDTH-1:0]          out_y_out,
  output logic signed [COORD_WIDTH-1:0]          out_z_out,
  output logic [crse_pkg::SEGMENT_WIDTH-1:0]     out_segment,
  output logic [crse_pkg::STATUS_WIDTH-1:0]      out_status
);
  import crse_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int TB   = T_FRAC_BITS;
  localparam int PTW  = 3 * CW;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SW   = TB + 1 + CNTW;
  localparam int QW   = CW + 3;
  localparam int AW   = (CW + 8 > TB + 1) ? CW + 8 : TB + 2;
  localparam int HW   = AW - TB;
  localparam int PHW  = AW + 2;
  localparam int PLW  = 2 * TB + 1;
  localparam int DW   = AW + 1;
  localparam int ND   = (DW + 3) / 4;
  localparam int PW   = 4 * ND;

  localparam logic [TB:0]          T_ONE    = {1'b1, {TB{1'b0}}};
  localparam logic [PLW:0]         HALF     = (PLW + 1)'(1) << (TB - 1);
  localparam logic [DW-1:0]        BIAS     = DW'(3) + (DW'(3) << (AW - 1));
  localparam logic [AW-1:0]        K_OFF    = {2'b01, {(AW - 2){1'b0}}};
  localparam logic [CW-1:0]        COORD_MX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0]        COORD_MN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CNTW-1:0]      CNT_FULL = CNTW'(MAX_POINTS);

  function automatic logic signed [CW-1:0] coord_of(input logic [PTW-1:0] p,
                                                    input logic [1:0] c);
    logic signed [CW-1:0] v;
    case (c)
      COORD_X: v = p[CW-1:0];
      COORD_Y: v = p[2*CW-1:CW];
      default: v = p[3*CW-1:2*CW];
    endcase
    return v;
  endfunction

  function automatic logic signed [QW-1:0] ext_q(input logic signed [CW-1:0] v);
    return {{3{v[CW-1]}}, v};
  endfunction

  function automatic logic signed [AW-1:0] ext_a(input logic signed [QW-1:0] v);
    return {{(AW - QW){v[QW-1]}}, v};
  endfunction

  // request
  logic                 op_r, first_r;
  logic [PTW-1:0]       ld_pt_r;
  logic [TB:0]          t_r;

  // list and outcome
  logic [CNTW-1:0]      count_r, count_nxt;
  logic [STATUS_WIDTH-1:0] stat_r, stat_nxt;
  logic                 full, few, load_ok;

  // segment search
  logic [SW-1:0]        s_r, s_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [TB:0]          u_r, u_nxt;
  logic [TB:0]          t_sat;
  logic [CNTW-1:0]      nm1;
  logic [CNTW:0]        s_hi;
  logic [TB-1:0]        s_frac;

  // point memory
  logic                 ram_we;
  logic [IW-1:0]        ram_addr, rd_addr, wr_addr;
  logic [PTW-1:0]       ram_rdata;
  logic [PTW-1:0]       pt_r [4];
  logic                 cap_v_r;
  logic [1:0]           cap_sel_r;

  // coefficients and Horner
  logic signed [CW-1:0] p0, p1, p2, p3;
  logic                 e0, e3;
  logic signed [QW-1:0] q0_r, q1_r, q2_r, q3_r;
  logic signed [QW-1:0] q0_nxt, q1_nxt, q2_nxt, q3_nxt;
  logic signed [AW-1:0] x0, x1, x2, x3, d12;
  logic signed [AW-1:0] a0_r, a1_r, a2_r, acc_r;
  logic signed [AW-1:0] a0_nxt, a1_nxt, a2_nxt, a3_nxt, acc_nxt, a_sel;
  logic signed [HW-1:0] qh;
  logic signed [TB+1:0] us;
  logic signed [PHW-1:0] ph_r, ph_nxt, sum;
  logic [PLW-1:0]       pl_r, pl_nxt;
  logic [PLW:0]         rnd_sum;

  // divide by six and saturate
  logic [DW-1:0]        dvd_load;
  logic [PW-1:0]        dvd_r, quo_r;
  logic [2:0]           rem_r;
  div6_t                dig;
  logic signed [AW-1:0] res_full;
  logic                 res_fits;
  logic signed [CW-1:0] res_sat;
  logic signed [CW-1:0] res_r [3];

  // output register
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [SEGMENT_WIDTH-1:0] out_seg_r;
  logic [STATUS_WIDTH-1:0]  out_status_r;

  // decode
  assign full    = (count_r == CNT_FULL);
  assign few     = (count_r < CNTW'(2));
  assign load_ok = (op_r == OP_LOAD) && (first_r || !full);
  assign stat.query_go = (op_r == OP_QUERY) && !few;

  always_comb begin
    count_nxt = count_r;
    if (cmd.decode && load_ok) begin
      count_nxt = first_r ? CNTW'(1) : count_r + CNTW'(1);
    end
    if (op_r == OP_QUERY) begin
      stat_nxt = few ? STATUS_FEW : STATUS_OK;
    end else if (!first_r && full) begin
      stat_nxt = STATUS_FULL;
    end else begin
      stat_nxt = STATUS_OK;
    end
  end

  // s = t * (n-1); segment and local parameter from s
  assign t_sat  = (t_r > T_ONE) ? T_ONE : t_r;
  assign nm1    = count_r - CNTW'(1);
  assign s_nxt  = {{CNTW{1'b0}}, t_sat} * {{(TB + 1){1'b0}}, nm1};
  assign s_hi   = s_r[SW-1:TB];
  assign s_frac = s_r[TB-1:0];

  always_comb begin
    if ((s_frac == '0) && (s_hi != '0)) begin
      idx_nxt = IW'(s_hi - (CNTW + 1)'(1));
      u_nxt   = T_ONE;
    end else begin
      idx_nxt = IW'(s_hi);
      u_nxt   = {1'b0, s_frac};
    end
  end

  // memory port: write on load, four reads around the segment on query
  assign wr_addr  = first_r ? '0 : IW'(count_r);
  assign rd_addr  = idx_r + IW'(cmd.sel) - IW'(1);
  assign ram_addr = cmd.decode ? wr_addr : rd_addr;
  assign ram_we   = cmd.decode && load_ok;

  crse_ram #(
    .WIDTH (PTW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ld_pt_r),
    .rdata (ram_rdata)
  );

  // scaled points; the ends get the extrapolated point
  assign p0 = coord_of(pt_r[0], cmd.sel);
  assign p1 = coord_of(pt_r[1], cmd.sel);
  assign p2 = coord_of(pt_r[2], cmd.sel);
  assign p3 = coord_of(pt_r[3], cmd.sel);
  assign e0 = (idx_r == '0);
  assign e3 = ((CNTW + 1)'(idx_r) + (CNTW + 1)'(2)) == (CNTW + 1)'(count_r);

  assign q0_nxt = e0 ? (ext_q(p1) <<< 2) - ext_q(p2) : ext_q(p0) + (ext_q(p0) <<< 1);
  assign q1_nxt = ext_q(p1) + (ext_q(p1) <<< 1);
  assign q2_nxt = ext_q(p2) + (ext_q(p2) <<< 1);
  assign q3_nxt = e3 ? (ext_q(p2) <<< 2) - ext_q(p1) : ext_q(p3) + (ext_q(p3) <<< 1);

  assign x0  = ext_a(q0_r);
  assign x1  = ext_a(q1_r);
  assign x2  = ext_a(q2_r);
  assign x3  = ext_a(q3_r);
  assign d12 = x1 - x2;

  assign a0_nxt = x1 <<< 1;
  assign a1_nxt = x2 - x0;
  assign a2_nxt = (x0 <<< 1) - ((x1 <<< 2) + x1) + (x2 <<< 2) - x3;
  assign a3_nxt = x3 - x0 + (d12 <<< 1) + d12;

  // product with u split at the binary point, rounded half up
  assign qh      = acc_r[AW-1:TB];
  assign us      = $signed({1'b0, u_r});
  assign ph_nxt  = qh * us;
  assign pl_nxt  = acc_r[TB-1:0] * u_r;
  assign rnd_sum = {1'b0, pl_r} + HALF;

  always_comb begin
    case (cmd.sel)
      STEP_A2: a_sel = a2_r;
      STEP_A1: a_sel = a1_r;
      default: a_sel = a0_r;
    endcase
  end

  assign sum     = ph_r + {{(PHW - TB - 2){1'b0}}, rnd_sum[PLW:TB]}
                 + {{(PHW - AW){a_sel[AW-1]}}, a_sel};
  assign acc_nxt = sum[AW-1:0];

  // biased so the dividend stays non-negative
  assign dvd_load = {acc_r[AW-1], acc_r} + BIAS;
  assign dig      = div6_digit({rem_r, dvd_r[PW-1 -: 4]});

  assign res_full = quo_r[AW-1:0] - K_OFF;
  assign res_fits = (&res_full[AW-1:CW-1]) || !(|res_full[AW-1:CW-1]);
  assign res_sat  = res_fits ? res_full[CW-1:0] : (res_full[AW-1] ? COORD_MN : COORD_MX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cap_v_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    cap_sel_r <= cmd.sel;
    if (cmd.capture) begin
      op_r    <= in_operation;
      first_r <= in_first_point;
      ld_pt_r <= {in_z_in, in_y_in, in_x_in};
      t_r     <= in_t_in;
    end
    if (cmd.decode) stat_r <= stat_nxt;
    if (cmd.scale) s_r <= s_nxt;
    if (cmd.index) begin
      idx_r <= idx_nxt;
      u_r   <= u_nxt;
    end
    if (cap_v_r) pt_r[cap_sel_r] <= ram_rdata;
    if (cmd.qpt) begin
      q0_r <= q0_nxt;
      q1_r <= q1_nxt;
      q2_r <= q2_nxt;
      q3_r <= q3_nxt;
    end
    if (cmd.coef) begin
      a0_r  <= a0_nxt;
      a1_r  <= a1_nxt;
      a2_r  <= a2_nxt;
      acc_r <= a3_nxt;
    end
    if (cmd.mul) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (cmd.add) acc_r <= acc_nxt;
    if (cmd.div_load) begin
      dvd_r <= PW'(dvd_load);
      quo_r <= '0;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[PW-5:0], 4'b0000};
      quo_r <= {quo_r[PW-5:0], dig.digit};
      rem_r <= dig.rem;
    end
    if (cmd.store) begin
      case (cmd.sel)
        COORD_X: res_r[0] <= res_sat;
        COORD_Y: res_r[1] <= res_sat;
        default: res_r[2] <= res_sat;
      endcase
    end
    if (cmd.publish) begin
      out_status_r <= stat_r;
      if ((op_r == OP_QUERY) && (stat_r == STATUS_OK)) begin
        out_x_r   <= res_r[0];
        out_y_r   <= res_r[1];
        out_z_r   <= res_r[2];
        out_seg_r <= SEGMENT_WIDTH'(idx_r);
      end else begin
        out_x_r   <= '0;
        out_y_r   <= '0;
        out_z_r   <= '0;
        out_seg_r <= '0;
      end
    end
  end

  assign out_x_out   = out_x_r;
  assign out_y_out   = out_y_r;
  assign out_z_out   = out_z_r;
  assign out_segment = out_seg_r;
  assign out_status  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode |=> count_r <= CNT_FULL)
    else $error("point count beyond capacity");

  a_segment_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.index |=> ((CNTW + 1)'(idx_r) + (CNTW + 1)'(2)) <= (CNTW + 1)'(count_r))
    else $error("segment index past the last segment");

endmodule

### rtl/catmull_rom_spline_eval.sv
// Uniform Catmull-Rom spline evaluator (tension one half) over up to MAX_POINTS
// control points in three dimensions. A request with operation 0 loads one point
// (first_point restarts the list); a load past capacity is dropped and answered
// with status 2. A request with operation 1 evaluates the curve at t in Q1.16
// (values above 1.0 clamp to 1.0): with n points there are n-1 segments, the
// segment is max(0, ceil(t*(n-1))-1), and the two ends are extended by an
// implicit point one third of the end chord beyond them. Coordinates are signed
// Q16.16, results saturated; fewer than two points gives status 1 and zeros.
// Every request returns exactly one result. Requests are handled one at a time:
// a load is decoded and published, a query is decoded and then evaluated. The
// divide produces DIV_DIGITS radix-16 digits, (COORD_WIDTH + 12) / 4 for the
// default ranges. The query time is set by the four point reads through the
// single port of the point memory and, per coordinate, by three multiply/add
// passes through one shared Horner unit and a radix-16 divide by six. The output
// register lets a finished result wait while the next request is taken in.
module catmull_rom_spline_eval #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic                               in_first_point,
  input  logic signed [COORD_WIDTH-1:0]      in_x_in,
  input  logic signed [COORD_WIDTH-1:0]      in_y_in,
  input  logic signed [COORD_WIDTH-1:0]      in_z_in,
  input  logic [T_FRAC_BITS:0]               in_t_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x_out,
  output logic signed [COORD_WIDTH-1:0]      out_y_out,
  output logic signed [COORD_WIDTH-1:0]      out_z_out,
  output logic [crse_pkg::SEGMENT_WIDTH-1:0] out_segment,
  output logic [crse_pkg::STATUS_WIDTH-1:0]  out_status
);
  import crse_pkg::*;

  // Accumulator keeps headroom for the three-times-scaled coefficients and
  // the Horner sums; the divider walks it four bits at a time.
  localparam int ACC_W      = (COORD_WIDTH + 8 > T_FRAC_BITS + 1) ?
                              COORD_WIDTH + 8 : T_FRAC_BITS + 2;
  localparam int DIV_DIGITS = (ACC_W + 4) / 4;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequence each request: decode and, for a query, segment search, point reads,
  // then per coordinate the coefficient build, Horner passes, divide, saturate.
  crse_ctrl #(
    .DIV_DIGITS (DIV_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Point memory, arithmetic and the output register.
  crse_dpath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_first_point (in_first_point),
    .in_x_in        (in_x_in),
    .in_y_in        (in_y_in),
    .in_z_in        (in_z_in),
    .in_t_in        (in_t_in),
    .out_x_out      (out_x_out),
    .out_y_out      (out_y_out),
    .out_z_out      (out_z_out),
    .out_segment    (out_segment),
    .out_status     (out_status)
  );

endmodule

### test/tb_top.sv
module tb_top;
  import crse_pkg::*;

  localparam int MAX_PTS      = 64;
  localparam int CW           = 32;
  localparam int TF           = 16;
  localparam int T_ONE        = 1 << TF;
  localparam int ITEMS        = 1350;
  // Bound on the whole run: busy time, idle gaps and long stalls stay far below this.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Give stray results time to show up.
  localparam int DRAIN_CYCLES = 120;

  // Receiver stall styles, switched periodically.
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_LONG, STALL_HEAVY} stall_mode_t;

  // Tracks the control point list and predicts one curve result per request.
  class spline_board;
    typedef struct packed {
      logic [2:0][CW-1:0]        coord;
      logic [SEGMENT_WIDTH-1:0]  segment;
      logic [STATUS_WIDTH-1:0]   status;
    } curve_pt_t;

    longint      ctrl_pts[MAX_PTS][3];
    int unsigned n_pts;
    curve_pt_t   results_due[$];
    int          errors;

    function new();
      n_pts  = 0;
      errors = 0;
    endfunction

    // Point k of the extended list at three times scale; ends are implicit.
    function longint end_point(int k, int n, int c);
      if (k == 0) return 4 * ctrl_pts[0][c] - ctrl_pts[1][c];
      if (k == n + 1) return 4 * ctrl_pts[n-1][c] - ctrl_pts[n-2][c];
      return 3 * ctrl_pts[k-1][c];
    endfunction

    // c*u scaled down by the t fraction, rounded to nearest, ties up.
    function longint scale_u(longint c, longint u);
      longint q;
      longint r;
      q = c >>> TF;
      r = c & longint'(T_ONE - 1);
      return q * u + ((r * u + longint'(T_ONE / 2)) >>> TF);
    endfunction

    // Divide the accumulator by six (round half up) and clamp to the coordinate range.
    function logic [CW-1:0] sat_div6(longint acc);
      longint q;
      longint hi;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      q  = (acc + 3) / 6;
      if ((acc + 3) % 6 < 0) q = q - 1;
      if (q > hi) q = hi;
      if (q < -hi - 1) q = -hi - 1;
      return q[CW-1:0];
    endfunction

    function void note_request(logic op, logic first, logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z, logic [TF:0] t);
      curve_pt_t r;
      longint    pt[3];
      longint    tc, s, idx, u, q0, q1, q2, q3, a0, a1, a2, a3, acc;
      int        n;
      r     = '0;
      pt[0] = $signed(x);
      pt[1] = $signed(y);
      pt[2] = $signed(z);
      if (op == OP_LOAD) begin
        // A first point restarts the list even when it is full.
        if (first) n_pts = 0;
        if (!first && n_pts >= MAX_PTS) begin
          r.status = STATUS_FULL;
        end else begin
          for (int c = 0; c < 3; c++) ctrl_pts[n_pts][c] = pt[c];
          n_pts++;
        end
      end else if (n_pts < 2) begin
        r.status = STATUS_FEW;
      end else begin
        n   = n_pts;
        tc  = (t > T_ONE) ? T_ONE : t;
        s   = tc * (n - 1);
        idx = (s == 0) ? 0 : ((s + T_ONE - 1) >>> TF) - 1;
        u   = s - (idx <<< TF);
        for (int c = 0; c < 3; c++) begin
          q0  = end_point(int'(idx), n, c);
          q1  = end_point(int'(idx) + 1, n, c);
          q2  = end_point(int'(idx) + 2, n, c);
          q3  = end_point(int'(idx) + 3, n, c);
          a0  = 2 * q1;
          a1  = q2 - q0;
          a2  = 2 * q0 - 5 * q1 + 4 * q2 - q3;
          a3  = -q0 + 3 * q1 - 3 * q2 + q3;
          acc = scale_u(a3, u) + a2;
          acc = scale_u(acc, u) + a1;
          acc = scale_u(acc, u) + a0;
          r.coord[c] = sat_div6(acc);
        end
        r.segment = idx[SEGMENT_WIDTH-1:0];
        r.status  = STATUS_OK;
      end
      results_due = {results_due, r};
    endfunction

    function void cmp_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic [SEGMENT_WIDTH-1:0] seg, logic [STATUS_WIDTH-1:0] status);
      curve_pt_t want;
      if (results_due.size() == 0) begin
        $error("result with no request pending: x %h y %h z %h segment %0d status %0d",
               x, y, z, seg, status);
        errors++;
        return;
      end
      want = results_due.pop_front();
      cmp_field("x_out", want.coord[0], x);
      cmp_field("y_out", want.coord[1], y);
      cmp_field("z_out", want.coord[2], z);
      cmp_field("segment", CW'(want.segment), CW'(seg));
      cmp_field("status", CW'(want.status), CW'(status));
    endfunction
  endclass

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_operation   = OP_LOAD;
  logic                     in_first_point = 1'b0;
  logic signed [CW-1:0]     in_x_in        = '0;
  logic signed [CW-1:0]     in_y_in        = '0;
  logic signed [CW-1:0]     in_z_in        = '0;
  logic [TF:0]              in_t_in        = '0;
  logic                     out_stall      = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [CW-1:0]     out_x_out;
  logic signed [CW-1:0]     out_y_out;
  logic signed [CW-1:0]     out_z_out;
  logic [SEGMENT_WIDTH-1:0] out_segment;
  logic [STATUS_WIDTH-1:0]  out_status;

  spline_board board = new();

  int unsigned cycles     = 0;
  int          burst_left = 0;
  int          sent       = 0;
  stall_mode_t stall_mode = STALL_NONE;

  catmull_rom_spline_eval #(
    .MAX_POINTS (MAX_PTS),
    .COORD_WIDTH(CW),
    .T_FRAC_BITS(TF)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_first_point(in_first_point),
    .in_x_in       (in_x_in),
    .in_y_in       (in_y_in),
    .in_z_in       (in_z_in),
    .in_t_in       (in_t_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_z_out     (out_z_out),
    .out_segment   (out_segment),
    .out_status    (out_status)
  );

  always #10 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result channel: pick a new style periodically, so some
  // stretches never stall and others hold results in long runs.
  always @(posedge clk) begin
    if (cycles % 400 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_LONG:   out_stall <= (cycles % 29 < 17);
      default:      out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Check every result taken at this edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_x_out, out_y_out, out_z_out, out_segment, out_status);
    end
  end

  // Half of them small so curves stay in range, the rest extremes and full-width
  // values to drive saturation and toggle every bit.
  function automatic logic [CW-1:0] rand_coord();
    logic [CW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       v = {1'b0, {(CW-1){1'b1}}};
      1:       v = {1'b1, {(CW-1){1'b0}}};
      2, 3, 4: ;
      default: v = {{(CW-21){v[20]}}, v[20:0]};
    endcase
    return v;
  endfunction

  // Parameter t: both ends, values above 1.0 (clamped), otherwise in range.
  function automatic logic [TF:0] rand_t();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return (TF+1)'(T_ONE);
      2:       return (TF+1)'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
      default: return (TF+1)'($urandom_range(0, T_ONE));
    endcase
  endfunction

  // Drive one request and hold it until taken. Idle between bursts of random
  // length; a gap of zero keeps valid high straight into the next burst.
  task automatic send_request(logic op, logic first, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z, logic [TF:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_first_point <= first;
    in_x_in        <= x;
    in_y_in        <= y;
    in_z_in        <= z;
    in_t_in        <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, first, x, y, z, t);
    burst_left--;
    sent++;
  endtask

  // Loads carry a junk t; queries carry junk coordinates and a junk first bit.
  task automatic load_point(logic first, logic [CW-1:0] x, logic [CW-1:0] y,
                            logic [CW-1:0] z);
    send_request(OP_LOAD, first, x, y, z, rand_t());
  endtask

  task automatic query_at(logic [TF:0] t);
    send_request(OP_QUERY, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                 rand_coord(), t);
  endtask

  initial begin
    int kind;
    int n_load;
    int n_query;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: query an empty list, then a single point.
    query_at((TF+1)'(T_ONE / 2));
    load_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    query_at('0);
    // Restart with extreme points; sweep t over both ends and the clamp.
    load_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    load_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    query_at('0);
    query_at((TF+1)'(T_ONE));
    query_at('1);
    query_at((TF+1)'(1));
    query_at((TF+1)'(T_ONE / 2));
    // Third point: segment boundary at t one half.
    load_point(1'b0, 32'h0000_0000, 32'h1234_5678, 32'h7FFF_FFFF);
    query_at((TF+1)'(T_ONE / 2));
    query_at((TF+1)'(T_ONE / 2 + 1));
    query_at((TF+1)'(T_ONE - 1));
    query_at((TF+1)'(T_ONE + 1));
    // A restart leaves one point.
    load_point(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    query_at((TF+1)'(T_ONE / 3));

    // Random: mostly whole curves (first point, loads, queries with random
    // content); some fill past capacity to hit the full-list drop and the
    // restart of a full list. The rest is one-point lists and raw noise.
    while (sent < ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        case ($urandom_range(0, 19))
          0:       n_load = MAX_PTS + $urandom_range(1, 4);
          1:       n_load = $urandom_range(9, MAX_PTS);
          default: n_load = $urandom_range(2, 8);
        endcase
        load_point(1'b1, rand_coord(), rand_coord(), rand_coord());
        repeat (n_load - 1) load_point(1'b0, rand_coord(), rand_coord(), rand_coord());
        n_query = $urandom_range(1, 8);
        repeat (n_query) query_at(rand_t());
        // Extend a live list and query again.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) load_point(1'b0, rand_coord(), rand_coord(),
                                                   rand_coord());
          repeat ($urandom_range(1, 4)) query_at(rand_t());
        end
      end else if (kind < 85) begin
        load_point(1'b1, rand_coord(), rand_coord(), rand_coord());
        query_at(rand_t());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_coord(),
                       rand_coord(), rand_coord(), (TF+1)'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every prediction, then watch for stray results.
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
